// ----- rtl/grpp_pkg.sv -----
// ----------------------------------------------------------------------------
// grpp_pkg
// Shared types, constants and print size tables of the page packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package grpp_pkg;

  localparam int unsigned COORD_W = 14;
  localparam int unsigned DIM_W   = 11;
  localparam int unsigned AREA_W  = 28;
  localparam int unsigned PROD_W  = AREA_W + COORD_W;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned PAGE_W  = 6;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned SIZE_W  = 2;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  localparam logic [STAT_W-1:0] ST_PLACED = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_FIT = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;

  localparam logic REG_MEDIA_W = 1'b0;
  localparam logic REG_MEDIA_H = 1'b1;

  typedef struct packed {
    logic               land;
    logic [SIZE_W-1:0]  size;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } placed_t;

  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } corner_t;

  function automatic logic [DIM_W-1:0] short_side(input logic [SIZE_W-1:0] sz);
    logic [DIM_W-1:0] r;
    case (sz)
      2'd0:    r = 11'd1152;
      2'd1:    r = 11'd792;
      2'd2:    r = 11'd576;
      default: r = 11'd360;
    endcase
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] long_side(input logic [SIZE_W-1:0] sz);
    logic [DIM_W-1:0] r;
    case (sz)
      2'd0:    r = 11'd1440;
      2'd1:    r = 11'd1008;
      2'd2:    r = 11'd720;
      default: r = 11'd504;
    endcase
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] dim_w(input logic [SIZE_W-1:0] sz, input logic land);
    return land ? long_side(sz) : short_side(sz);
  endfunction

  function automatic logic [DIM_W-1:0] dim_h(input logic [SIZE_W-1:0] sz, input logic land);
    return land ? short_side(sz) : long_side(sz);
  endfunction

  function automatic logic [AREA_W-1:0] print_area(input logic [SIZE_W-1:0] sz);
    logic [AREA_W-1:0] r;
    case (sz)
      2'd0:    r = 28'd1658880;
      2'd1:    r = 28'd798336;
      2'd2:    r = 28'd414720;
      default: r = 28'd181440;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/grpp_if.sv -----
// ----------------------------------------------------------------------------
// grpp_if
// Job and result channels of the page packer (valid/ready).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface grpp_job_if;
  logic                       valid;
  logic                       ready;
  logic [grpp_pkg::CNT_W-1:0] count_16x20;
  logic [grpp_pkg::CNT_W-1:0] count_11x14;
  logic [grpp_pkg::CNT_W-1:0] count_8x10;
  logic [grpp_pkg::CNT_W-1:0] count_5x7;

  modport source (output valid, count_16x20, count_11x14, count_8x10, count_5x7,
                  input ready);
  modport sink   (input valid, count_16x20, count_11x14, count_8x10, count_5x7,
                  output ready);
endinterface

interface grpp_res_if;
  logic                         valid;
  logic                         ready;
  logic [grpp_pkg::STAT_W-1:0]  status;
  logic [grpp_pkg::PAGE_W-1:0]  page_index;
  logic [grpp_pkg::COORD_W-1:0] pos_x;
  logic [grpp_pkg::COORD_W-1:0] pos_y;
  logic [grpp_pkg::SIZE_W-1:0]  size_index;
  logic                         landscape;
  logic                         last;

  modport source (output valid, status, page_index, pos_x, pos_y, size_index, landscape,
                  last, input ready);
  modport sink   (input valid, status, page_index, pos_x, pos_y, size_index, landscape,
                  last, output ready);
endinterface

`default_nettype wire

// ----- rtl/greedy_rectangle_page_packer_unit.sv -----
// ----------------------------------------------------------------------------
// greedy_rectangle_page_packer_unit
// Greedy corner-point packer of four print sizes onto pages of set media.
//
//   channel  | dir | handshake          | contents
//   job_i    | in  | valid/ready        | four print counts
//   res_o    | out | valid/ready        | status, page, x, y, size, landscape, last
//   apb      | in  | psel/penable/pready| media width (0x0), media height (0x4)
//
// One job runs alone; job_i.ready is high only between jobs. Per placement
// the sequencer walks the corner list and tries each candidate at a corner;
// a candidate with prints left that lies inside the media scans the placed
// store one entry a cycle (ends early on a hit), and any fit after the first
// goes through the shared multiplier. Then the kept corners are copied back
// and the two new ones appended, plus the setup, decide, commit and result
// steps. A result waiting on res_o stalls the sequencer at its next result.
// Reset clears the registers but not the corner and placed memories.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module greedy_rectangle_page_packer_unit #(
  parameter int unsigned MAX_PLACED  = 64,
  parameter int unsigned MAX_CORNERS = 64,
  parameter int unsigned COUNT_WIDTH = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  grpp_job_if.sink                           job_i,
  grpp_res_if.source                         res_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [grpp_pkg::APB_AW-1:0]   paddr,
  input  wire logic [grpp_pkg::APB_DW-1:0]   pwdata,
  output logic      [grpp_pkg::APB_DW-1:0]   prdata,
  output logic                               pready
);

  localparam int unsigned PCW = $clog2(MAX_PLACED + 1);
  localparam int unsigned PIW = $clog2(MAX_PLACED);
  localparam int unsigned CCW = $clog2(MAX_CORNERS + 1);
  localparam int unsigned CIW = $clog2(MAX_CORNERS);
  localparam int unsigned CW  = COUNT_WIDTH;
  localparam int unsigned TW  = COUNT_WIDTH + 2;
  localparam int unsigned LW  = (COUNT_WIDTH < grpp_pkg::CNT_W) ? COUNT_WIDTH
                                                                 : grpp_pkg::CNT_W;
  localparam int unsigned XW  = grpp_pkg::COORD_W;
  localparam int unsigned SW  = grpp_pkg::COORD_W + 1;
  localparam int unsigned DW  = grpp_pkg::DIM_W;
  localparam int unsigned AW  = grpp_pkg::AREA_W;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_CRD, S_CGET, S_CAND, S_OVL, S_MULA, S_MULB,
    S_CMP, S_CEND, S_DECIDE, S_CPY, S_APP1, S_APP2, S_COMMIT, S_EMIT
  } state_e;

  // configuration
  logic [XW-1:0] mw_q, mh_q;
  logic          cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  assign prdata = (paddr[2] == grpp_pkg::REG_MEDIA_H) ? grpp_pkg::APB_DW'(mh_q)
                                                      : grpp_pkg::APB_DW'(mw_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mw_q <= XW'(612);
      mh_q <= XW'(792);
    end else if (cfg_we) begin
      if (paddr[2] == grpp_pkg::REG_MEDIA_H) begin
        mh_q <= pwdata[XW-1:0];
      end else begin
        mw_q <= pwdata[XW-1:0];
      end
    end
  end

  // state
  state_e                       state_q;
  logic [CW-1:0]                rem_q [4];
  logic [TW-1:0]                total_q;
  logic [grpp_pkg::PAGE_W-1:0]  page_q;
  logic [PCW-1:0]               pcnt_q, k_q;
  logic [CCW-1:0]               ccnt_q, j_q, nk_q, best_q, u_q, cpu_q, t_q;
  logic [XW-1:0]                hused_q, cx_q, cy_q, nh_q, bx_q, by_q, bheight_q;
  logic [AW-1:0]                aused_q, na_q, barea_q;
  logic [DW-1:0]                cw_q, ch_q, bw_q, bh_q;
  logic                         found_q, usable_q, opv_q, cpv_q, bld_q;
  logic [2:0]                   cand_q;
  logic [1:0]                   bsz_q;
  logic [grpp_pkg::PROD_W-1:0]  p1_q;
  logic [grpp_pkg::STAT_W-1:0]  em_st_q;
  logic                         em_last_q;

  logic                         rv_q, out_land_q, out_last_q;
  logic [grpp_pkg::STAT_W-1:0]  out_st_q;
  logic [grpp_pkg::PAGE_W-1:0]  out_page_q;
  logic [XW-1:0]                out_x_q, out_y_q;
  logic [1:0]                   out_size_q;

  // memories
  grpp_pkg::corner_t cmem [MAX_CORNERS];
  grpp_pkg::corner_t kmem [MAX_CORNERS];
  grpp_pkg::placed_t pmem [MAX_PLACED];
  grpp_pkg::corner_t cmem_rd, kmem_rd, cmem_wd;
  grpp_pkg::placed_t pmem_rd, pmem_wd;
  logic              cmem_we, kmem_we, pmem_we;
  logic [CIW-1:0]    cmem_wa, cmem_ra;
  logic [CCW-1:0]    jm1;

  // datapath
  logic [CW-1:0]   ld [4];
  logic [3:0]      cnt_in [4];
  logic [TW-1:0]   tot_c;
  logic            job_acc, fit, ov_hit, cand_last, start_pg;
  logic [1:0]      cs;
  logic [DW-1:0]   cand_w, cand_h;
  logic [SW-1:0]   xsum, ysum;
  logic [XW-1:0]   nh_c;
  logic [AW-1:0]   na_c, mul_a;
  logic [XW-1:0]   mul_b;
  logic [grpp_pkg::PROD_W-1:0] mul_p;

  assign cnt_in[0] = job_i.count_16x20;
  assign cnt_in[1] = job_i.count_11x14;
  assign cnt_in[2] = job_i.count_8x10;
  assign cnt_in[3] = job_i.count_5x7;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ld[i] = CW'(cnt_in[i][LW-1:0]);
    end
    tot_c = TW'(ld[0]) + TW'(ld[1]) + TW'(ld[2]) + TW'(ld[3]);
  end

  assign job_i.ready = (state_q == S_IDLE);
  assign job_acc     = job_i.valid & job_i.ready;

  always_comb begin
    cs        = cand_q[2:1];
    cand_w    = grpp_pkg::dim_w(cs, cand_q[0]);
    cand_h    = grpp_pkg::dim_h(cs, cand_q[0]);
    xsum      = SW'(cx_q) + SW'(cand_w);
    ysum      = SW'(cy_q) + SW'(cand_h);
    fit       = (rem_q[cs] != '0) && (xsum <= SW'(mw_q)) && (ysum <= SW'(mh_q));
    nh_c      = (ysum > SW'(hused_q)) ? ysum[XW-1:0] : hused_q;
    na_c      = aused_q + grpp_pkg::print_area(cs);
    cand_last = (cand_q == 3'd7);
  end

  grpp_ovl u_ovl (
    .cx_i    (cx_q),
    .cy_i    (cy_q),
    .cw_i    (cw_q),
    .ch_i    (ch_q),
    .entry_i (pmem_rd),
    .hit_o   (ov_hit)
  );

  assign mul_a = (state_q == S_MULA) ? na_q : barea_q;
  assign mul_b = (state_q == S_MULA) ? bheight_q : nh_q;

  grpp_mul u_mul (
    .clk_i    (clk_i),
    .area_i   (mul_a),
    .height_i (mul_b),
    .prod_o   (mul_p)
  );

  // memory ports
  assign start_pg = (job_acc && tot_c != '0) ||
                    (state_q == S_DECIDE && !found_q && pcnt_q != '0);
  assign jm1      = j_q - 1'b1;
  assign cmem_ra  = jm1[CIW-1:0];

  always_comb begin
    cmem_we = 1'b0;
    cmem_wa = t_q[CIW-1:0];
    cmem_wd = kmem_rd;
    if (start_pg) begin
      cmem_we = 1'b1;
      cmem_wa = '0;
      cmem_wd = '0;
    end else if (state_q == S_CPY) begin
      cmem_we = cpv_q && (cpu_q != best_q);
    end else if (state_q == S_APP1) begin
      cmem_we   = (t_q != CCW'(MAX_CORNERS));
      cmem_wd.x = XW'(SW'(bx_q) + SW'(bw_q));
      cmem_wd.y = by_q;
    end else if (state_q == S_APP2) begin
      cmem_we   = (t_q != CCW'(MAX_CORNERS));
      cmem_wd.x = bx_q;
      cmem_wd.y = XW'(SW'(by_q) + SW'(bh_q));
    end
  end

  assign kmem_we = (state_q == S_CEND) && usable_q && (nk_q != CCW'(MAX_CORNERS));
  assign pmem_we = (state_q == S_COMMIT);
  always_comb begin
    pmem_wd.x    = bx_q;
    pmem_wd.y    = by_q;
    pmem_wd.size = bsz_q;
    pmem_wd.land = bld_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmem_we) begin
      cmem[cmem_wa] <= cmem_wd;
    end
    cmem_rd <= cmem[cmem_ra];
  end

  always_ff @(posedge clk_i) begin
    if (kmem_we) begin
      kmem[nk_q[CIW-1:0]] <= {cy_q, cx_q};
    end
    kmem_rd <= kmem[u_q[CIW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (pmem_we) begin
      pmem[pcnt_q[PIW-1:0]] <= pmem_wd;
    end
    pmem_rd <= pmem[k_q[PIW-1:0]];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      for (int i = 0; i < 4; i++) begin
        rem_q[i] <= '0;
      end
      total_q    <= '0;
      page_q     <= '0;
      pcnt_q     <= '0;
      ccnt_q     <= '0;
      hused_q    <= '0;
      aused_q    <= '0;
      k_q        <= '0;
      j_q        <= '0;
      nk_q       <= '0;
      best_q     <= '0;
      u_q        <= '0;
      cpu_q      <= '0;
      t_q        <= '0;
      cx_q       <= '0;
      cy_q       <= '0;
      nh_q       <= '0;
      na_q       <= '0;
      cw_q       <= '0;
      ch_q       <= '0;
      bx_q       <= '0;
      by_q       <= '0;
      bw_q       <= '0;
      bh_q       <= '0;
      bsz_q      <= '0;
      bld_q      <= 1'b0;
      bheight_q  <= '0;
      barea_q    <= '0;
      found_q    <= 1'b0;
      usable_q   <= 1'b0;
      opv_q      <= 1'b0;
      cpv_q      <= 1'b0;
      cand_q     <= '0;
      p1_q       <= '0;
      em_st_q    <= grpp_pkg::ST_PLACED;
      em_last_q  <= 1'b0;
      rv_q       <= 1'b0;
      out_st_q   <= grpp_pkg::ST_PLACED;
      out_page_q <= '0;
      out_x_q    <= '0;
      out_y_q    <= '0;
      out_size_q <= '0;
      out_land_q <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      if (rv_q && res_o.ready && state_q != S_EMIT) begin
        rv_q <= 1'b0;
      end
      if (start_pg) begin
        pcnt_q  <= '0;
        ccnt_q  <= CCW'(1);
        hused_q <= '0;
        aused_q <= '0;
      end
      case (state_q)
        S_IDLE: begin
          if (job_acc) begin
            for (int i = 0; i < 4; i++) begin
              rem_q[i] <= ld[i];
            end
            total_q <= tot_c;
            page_q  <= '0;
            if (tot_c == '0) begin
              em_st_q   <= grpp_pkg::ST_EMPTY;
              em_last_q <= 1'b1;
              bx_q      <= '0;
              by_q      <= '0;
              bsz_q     <= '0;
              bld_q     <= 1'b0;
              state_q   <= S_EMIT;
            end else begin
              state_q <= S_INIT;
            end
          end
        end
        S_INIT: begin
          nk_q    <= '0;
          found_q <= 1'b0;
          if (pcnt_q != PCW'(MAX_PLACED) && ccnt_q != '0) begin
            j_q     <= ccnt_q;
            state_q <= S_CRD;
          end else begin
            state_q <= S_DECIDE;
          end
        end
        S_CRD: begin
          j_q     <= jm1;
          state_q <= S_CGET;
        end
        S_CGET: begin
          cx_q     <= cmem_rd.x;
          cy_q     <= cmem_rd.y;
          cand_q   <= '0;
          usable_q <= 1'b0;
          state_q  <= S_CAND;
        end
        S_CAND: begin
          if (fit) begin
            cw_q    <= cand_w;
            ch_q    <= cand_h;
            nh_q    <= nh_c;
            na_q    <= na_c;
            k_q     <= '0;
            opv_q   <= 1'b0;
            state_q <= S_OVL;
          end else if (cand_last) begin
            state_q <= S_CEND;
          end else begin
            cand_q <= cand_q + 3'd1;
          end
        end
        S_OVL: begin
          if (opv_q && ov_hit) begin
            opv_q   <= 1'b0;
            cand_q  <= cand_q + 3'd1;
            state_q <= cand_last ? S_CEND : S_CAND;
          end else if (k_q != pcnt_q) begin
            k_q   <= k_q + 1'b1;
            opv_q <= 1'b1;
          end else if (opv_q) begin
            opv_q <= 1'b0;
          end else begin
            usable_q <= 1'b1;
            if (!found_q) begin
              found_q   <= 1'b1;
              bx_q      <= cx_q;
              by_q      <= cy_q;
              bw_q      <= cw_q;
              bh_q      <= ch_q;
              bsz_q     <= cand_q[2:1];
              bld_q     <= cand_q[0];
              bheight_q <= nh_q;
              barea_q   <= na_q;
              best_q    <= nk_q;
              cand_q    <= cand_q + 3'd1;
              state_q   <= cand_last ? S_CEND : S_CAND;
            end else begin
              state_q <= S_MULA;
            end
          end
        end
        S_MULA: begin
          state_q <= S_MULB;
        end
        S_MULB: begin
          p1_q    <= mul_p;
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (p1_q > mul_p) begin
            bx_q      <= cx_q;
            by_q      <= cy_q;
            bw_q      <= cw_q;
            bh_q      <= ch_q;
            bsz_q     <= cand_q[2:1];
            bld_q     <= cand_q[0];
            bheight_q <= nh_q;
            barea_q   <= na_q;
            best_q    <= nk_q;
          end
          cand_q  <= cand_q + 3'd1;
          state_q <= cand_last ? S_CEND : S_CAND;
        end
        S_CEND: begin
          if (kmem_we) begin
            nk_q <= nk_q + 1'b1;
          end
          state_q <= (j_q == '0) ? S_DECIDE : S_CRD;
        end
        S_DECIDE: begin
          if (found_q) begin
            u_q     <= '0;
            cpv_q   <= 1'b0;
            t_q     <= '0;
            state_q <= S_CPY;
          end else if (pcnt_q == '0) begin
            em_st_q   <= grpp_pkg::ST_NO_FIT;
            em_last_q <= 1'b1;
            bx_q      <= '0;
            by_q      <= '0;
            bsz_q     <= '0;
            bld_q     <= 1'b0;
            state_q   <= S_EMIT;
          end else begin
            page_q  <= page_q + 1'b1;
            state_q <= S_INIT;
          end
        end
        S_CPY: begin
          if (cmem_we) begin
            t_q <= t_q + 1'b1;
          end
          if (u_q != nk_q) begin
            u_q   <= u_q + 1'b1;
            cpu_q <= u_q;
            cpv_q <= 1'b1;
          end else if (cpv_q) begin
            cpv_q <= 1'b0;
          end else begin
            state_q <= S_APP1;
          end
        end
        S_APP1: begin
          if (cmem_we) begin
            t_q <= t_q + 1'b1;
          end
          state_q <= S_APP2;
        end
        S_APP2: begin
          if (cmem_we) begin
            t_q <= t_q + 1'b1;
          end
          state_q <= S_COMMIT;
        end
        S_COMMIT: begin
          ccnt_q        <= t_q;
          hused_q       <= bheight_q;
          aused_q       <= barea_q;
          pcnt_q        <= pcnt_q + 1'b1;
          rem_q[bsz_q]  <= rem_q[bsz_q] - 1'b1;
          total_q       <= total_q - 1'b1;
          em_st_q       <= grpp_pkg::ST_PLACED;
          em_last_q     <= (total_q == TW'(1));
          state_q       <= S_EMIT;
        end
        S_EMIT: begin
          if (!rv_q || res_o.ready) begin
            rv_q       <= 1'b1;
            out_st_q   <= em_st_q;
            out_page_q <= page_q;
            out_x_q    <= bx_q;
            out_y_q    <= by_q;
            out_size_q <= bsz_q;
            out_land_q <= bld_q;
            out_last_q <= em_last_q;
            state_q    <= em_last_q ? S_IDLE : S_INIT;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o.valid      = rv_q;
  assign res_o.status     = out_st_q;
  assign res_o.page_index = out_page_q;
  assign res_o.pos_x      = out_x_q;
  assign res_o.pos_y      = out_y_q;
  assign res_o.size_index = out_size_q;
  assign res_o.landscape  = out_land_q;
  assign res_o.last       = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/grpp_mul.sv -----
// ----------------------------------------------------------------------------
// grpp_mul
// Shared registered area x height multiplier for the ratio compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grpp_mul (
  input  wire logic                          clk_i,
  input  wire logic [grpp_pkg::AREA_W-1:0]   area_i,
  input  wire logic [grpp_pkg::COORD_W-1:0]  height_i,
  output logic      [grpp_pkg::PROD_W-1:0]   prod_o
);

  always_ff @(posedge clk_i) begin
    prod_o <= grpp_pkg::PROD_W'(area_i) * grpp_pkg::PROD_W'(height_i);
  end

endmodule

`default_nettype wire

// ----- rtl/grpp_ovl.sv -----
// ----------------------------------------------------------------------------
// grpp_ovl
// Rectangle intersection test of a candidate against one placed print.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grpp_ovl (
  input  wire logic [grpp_pkg::COORD_W-1:0] cx_i,
  input  wire logic [grpp_pkg::COORD_W-1:0] cy_i,
  input  wire logic [grpp_pkg::DIM_W-1:0]   cw_i,
  input  wire logic [grpp_pkg::DIM_W-1:0]   ch_i,
  input  wire grpp_pkg::placed_t            entry_i,
  output logic                              hit_o
);

  localparam int unsigned SW = grpp_pkg::COORD_W + 1;

  logic [grpp_pkg::DIM_W-1:0] pw, ph;
  logic [SW-1:0] px_end, py_end, cx_end, cy_end;

  always_comb begin
    pw     = grpp_pkg::dim_w(entry_i.size, entry_i.land);
    ph     = grpp_pkg::dim_h(entry_i.size, entry_i.land);
    px_end = SW'(entry_i.x) + SW'(pw);
    py_end = SW'(entry_i.y) + SW'(ph);
    cx_end = SW'(cx_i) + SW'(cw_i);
    cy_end = SW'(cy_i) + SW'(ch_i);
    hit_o  = (SW'(cx_i) < px_end) && (SW'(entry_i.x) < cx_end) &&
             (SW'(cy_i) < py_end) && (SW'(entry_i.y) < cy_end);
  end

endmodule

`default_nettype wire
